// ===== rtl/mh2_pkg.sv =====
package mh2_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned TailW = 24;

  localparam logic [HashW-1:0] MH_MUL     = 32'h5bd1e995;
  localparam logic [HashW-1:0] SEED_RESET = 32'd464;

  localparam int unsigned KShift   = 24;
  localparam int unsigned AvShiftA = 13;
  localparam int unsigned AvShiftB = 15;

endpackage

// ===== rtl/mh2_mul.sv =====
module mh2_mul
  import mh2_pkg::*;
(
  input  logic             clk_i,
  input  logic [HashW-1:0] a_i,
  output logic [HashW-1:0] prod_o
);

  logic [HashW-1:0] prod_q;
  logic [HashW-1:0] prod_d;

  // low word of a * m
  assign prod_d = a_i * MH_MUL;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/murmurhash2_byte_stream.sv =====
// A byte that does not complete a word is taken without holding the input; a byte that
// completes a word holds the input in K1, K2, HM (two k multiplies, one h multiply).
// A last item raises m_axis_tvalid after its word, tail and avalanche multiplies and
// holds the input as long; a waiting hash stalls the avalanche.
// All multiplies share one registered 32x32 multiplier, one product per cycle.
// Reset (rst_ni low, asynchronous) clears the hash state and loads seed 464.
module murmurhash2_byte_stream
  import mh2_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [HashW-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [39:0]      s_axis_tdata,   // [7:0] data_byte, [39:8] message_length
  input  logic             s_axis_tuser,   // [0] first_byte
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata    // [31:0] hash_value
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_K1   = 4'd1;
  localparam logic [3:0] ST_K2   = 4'd2;
  localparam logic [3:0] ST_HM   = 4'd3;
  localparam logic [3:0] ST_TL   = 4'd4;
  localparam logic [3:0] ST_TLW  = 4'd5;
  localparam logic [3:0] ST_AV   = 4'd6;
  localparam logic [3:0] ST_AVW  = 4'd7;

  logic [3:0]       state_q, state_d;
  logic [HashW-1:0] seed_q;
  logic [HashW-1:0] h_q, h_d;
  logic [TailW-1:0] wb_q, wb_d;
  logic [1:0]       pos_q, pos_d;
  logic             last_q, last_d;
  logic [HashW-1:0] k_q, k_d;
  logic             out_vld_q, out_vld_d;
  logic [HashW-1:0] out_q, out_d;

  logic [HashW-1:0] mul_a;
  logic [HashW-1:0] prod;

  logic             accept;
  logic [ByteW-1:0] in_byte;
  logic [HashW-1:0] in_len;
  logic [HashW-1:0] h_n;
  logic [TailW-1:0] wb_n;
  logic [1:0]       pos_n;
  logic             take;
  logic             mix;

  mh2_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .prod_o (prod)
  );

  assign in_byte       = s_axis_tdata[7:0];
  assign in_len        = s_axis_tdata[39:8];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    h_n   = h_q;
    wb_n  = wb_q;
    pos_n = pos_q;
    take  = 1'b1;
    if (s_axis_tuser) begin
      h_n   = seed_q ^ in_len;
      wb_n  = '0;
      pos_n = '0;
      take  = (in_len != '0);
    end
    mix = take && (pos_n == 2'd3);
  end

  always_comb begin
    state_d   = state_q;
    h_d       = h_q;
    wb_d      = wb_q;
    pos_d     = pos_q;
    last_d    = last_q;
    k_d       = k_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    mul_a     = '0;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          h_d    = h_n;
          last_d = s_axis_tlast;
          if (mix) begin
            mul_a   = {in_byte, wb_n};
            wb_d    = '0;
            pos_d   = '0;
            state_d = ST_K1;
          end else begin
            wb_d  = wb_n;
            pos_d = pos_n;
            if (take) begin
              case (pos_n)
                2'd0:    wb_d[7:0]   = in_byte;
                2'd1:    wb_d[15:8]  = in_byte;
                default: wb_d[23:16] = in_byte;
              endcase
              pos_d = pos_n + 2'd1;
            end
            if (s_axis_tlast) begin
              state_d = (pos_d != 2'd0) ? ST_TL : ST_AV;
            end
          end
        end
      end
      ST_K1: begin
        mul_a   = prod ^ (prod >> KShift);
        state_d = ST_K2;
      end
      ST_K2: begin
        k_d     = prod;
        mul_a   = h_q;
        state_d = ST_HM;
      end
      ST_HM: begin
        h_d     = prod ^ k_q;
        state_d = last_q ? ST_AV : ST_IDLE;
      end
      ST_TL: begin
        mul_a   = h_q ^ {{(HashW-TailW){1'b0}}, wb_q};
        state_d = ST_TLW;
      end
      ST_TLW: begin
        h_d     = prod;
        state_d = ST_AV;
      end
      ST_AV: begin
        if (!out_vld_q || m_axis_tready) begin
          mul_a   = h_q ^ (h_q >> AvShiftA);
          state_d = ST_AVW;
        end
      end
      ST_AVW: begin
        out_d     = prod ^ (prod >> AvShiftB);
        out_vld_d = 1'b1;
        h_d       = '0;
        wb_d      = '0;
        pos_d     = '0;
        last_d    = 1'b0;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      seed_q    <= SEED_RESET;
      h_q       <= '0;
      wb_q      <= '0;
      pos_q     <= '0;
      last_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      h_q       <= h_d;
      wb_q      <= wb_d;
      pos_q     <= pos_d;
      last_q    <= last_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    out_q <= out_d;
  end

`ifndef ASSERT_OFF
  a_k1_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_K1) |-> ($past(state_q) == ST_IDLE))
    else $error("word mix started outside idle");

  a_last_runs_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (state_q != ST_IDLE))
    else $error("last item did not start finalization");

  a_fin_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AVW) |=> (out_vld_q && (state_q == ST_IDLE) && (pos_q == 2'd0)))
    else $error("finalization did not emit a hash");
`endif

endmodule

// ===== verif/murmurhash2_hash_checker.sv =====
module murmurhash2_hash_checker
  import mh2_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [HashW-1:0] cfg_wdata_i,
  input  logic             s_valid_i,
  input  logic             s_ready_i,
  input  logic [39:0]      s_data_i,   // [7:0] data_byte, [39:8] message_length
  input  logic             s_user_i,   // [0] first_byte
  input  logic             s_last_i,
  input  logic             m_valid_i,
  input  logic             m_ready_i,
  input  logic [31:0]      m_data_i,   // [31:0] hash_value
  output int               errors_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [HashW-1:0] seed_q = SEED_RESET;
  logic [HashW-1:0] hash_q = '0;
  logic [TailW-1:0] tail_q = '0;
  logic [1:0]       fill_q = '0;
  logic [HashW-1:0] hashes_due[$];

  function automatic logic [HashW-1:0] fold_word(logic [HashW-1:0] h, logic [HashW-1:0] k);
    k = k * MH_MUL;
    k = k ^ (k >> KShift);
    k = k * MH_MUL;
    return (h * MH_MUL) ^ k;
  endfunction

  function automatic logic [HashW-1:0] finish_hash(logic [HashW-1:0] h);
    h = h ^ (h >> AvShiftA);
    h = h * MH_MUL;
    return h ^ (h >> AvShiftB);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s, got %08h, expected %08h", $realtime, what, got, want);
    errors_o++;
  endtask

  task automatic absorb_byte(input logic [ByteW-1:0] b, input logic first,
                             input logic [HashW-1:0] len, input logic last);
    logic [HashW-1:0] h;
    logic [TailW-1:0] wb;
    logic [1:0]       pos;
    logic             take;
    h    = hash_q;
    wb   = tail_q;
    pos  = fill_q;
    take = 1'b1;
    if (first) begin
      h    = seed_q ^ len;
      wb   = '0;
      pos  = '0;
      take = (len != '0);
    end
    if (take) begin
      if (pos == 2'd3) begin
        h   = fold_word(h, {b, wb});
        wb  = '0;
        pos = '0;
      end else begin
        wb  = wb | (TailW'(b) << (8 * pos));
        pos = pos + 2'd1;
      end
    end
    if (last) begin
      if (pos != 2'd0) begin
        h = (h ^ {8'h00, wb}) * MH_MUL;
      end
      hashes_due.push_back(finish_hash(h));
      hash_q = '0;
      tail_q = '0;
      fill_q = '0;
    end else begin
      hash_q = h;
      tail_q = wb;
      fill_q = pos;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q = SEED_RESET;
      hash_q = '0;
      tail_q = '0;
      fill_q = '0;
      hashes_due.delete();
    end else begin
      if (cfg_we_i) begin
        seed_q = cfg_wdata_i;
      end
      if (m_valid_i && m_ready_i) begin
        if (hashes_due.size() == 0) begin
          report_mismatch("hash with none due", m_data_i, '0);
        end else if (m_data_i !== hashes_due[0]) begin
          report_mismatch("hash_value", m_data_i, hashes_due[0]);
          void'(hashes_due.pop_front());
        end else begin
          void'(hashes_due.pop_front());
        end
      end
      if (s_valid_i && s_ready_i) begin
        absorb_byte(s_data_i[7:0], s_user_i, s_data_i[39:8], s_last_i);
      end
    end
    pending_o = hashes_due.size();
  end

endmodule

// ===== verif/murmurhash2_byte_stream_test.sv =====
module murmurhash2_byte_stream_test
  import mh2_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [HashW-1:0] cfg_wdata_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [39:0]      s_axis_tdata;   // [7:0] data_byte, [39:8] message_length
  logic             s_axis_tuser;   // [0] first_byte
  logic             s_axis_tlast;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [31:0]      m_axis_tdata;   // [31:0] hash_value

  int          errors;
  int          pending;
  int unsigned bytes_sent = 0;
  int unsigned rx_hold_len = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;

  always #6 clk_i = ~clk_i;

  murmurhash2_byte_stream uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  murmurhash2_hash_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_i  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .s_user_i   (s_axis_tuser),
    .s_last_i   (s_axis_tlast),
    .m_valid_i  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_i   (m_axis_tdata),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    #8ms;
    $display("tb: failure");
    $finish;
  end

  // hash receiver
  initial begin
    int unsigned pause;
    m_axis_tready = 1'b0;
    forever begin
      pause = rx_idle ? $urandom_range(17, 0) : 0;
      if (rx_hold_len != 0) begin
        pause       = rx_hold_len;
        rx_hold_len = 0;
      end
      if (pause != 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic first,
                           input logic [31:0] len, input logic last);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(17, 0) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, b};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_message(input int unsigned n, input logic [31:0] len,
                              input bit mark_last);
    for (int unsigned i = 0; i < n; i++) begin
      push_byte(8'($urandom), i == 0, (i == 0) ? len : 32'($urandom),
                mark_last && (i == n - 1));
    end
  endtask

  // drop valid, wait for every hash, let the block settle
  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_seed(input logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned kind;
    int unsigned n;
    int unsigned phase_end;
    int unsigned phase;
    logic [31:0] len;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty message, single bytes, length mismatch
    push_byte(8'hFF, 1'b1, 32'd0, 1'b1);
    push_byte(8'h00, 1'b1, 32'd1, 1'b1);
    push_byte(8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
    // one whole word, then word plus a three byte tail
    push_byte(8'h00, 1'b1, 32'd4, 1'b0);
    push_byte(8'hFF, 1'b0, 32'd0, 1'b0);
    push_byte(8'hA5, 1'b0, 32'd0, 1'b0);
    push_byte(8'h5A, 1'b0, 32'd0, 1'b1);
    send_message(7, 32'd7, 1'b1);
    // bytes with no first mark after a message ended
    push_byte(8'h3C, 1'b0, 32'($urandom), 1'b0);
    push_byte(8'hC3, 1'b0, 32'($urandom), 1'b1);
    // zero length on a first item that is not last
    push_byte(8'h77, 1'b1, 32'd0, 1'b0);
    push_byte(8'h12, 1'b0, 32'd0, 1'b0);
    push_byte(8'h34, 1'b0, 32'd0, 1'b1);
    // restart in the middle of a message
    push_byte(8'h01, 1'b1, 32'd9, 1'b0);
    push_byte(8'h02, 1'b1, 32'd2, 1'b1);

    phase = 0;
    bytes_sent = 0;
    while (bytes_sent < 1400) begin
      drain_stream();
      case (phase)
        0:       write_seed(32'h0000_0000);
        1:       write_seed(32'hFFFF_FFFF);
        default: write_seed(32'($urandom));
      endcase
      tx_idle = (phase % 3) != 1;
      rx_idle = (phase % 3) != 2;
      if (phase == 3) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      if (phase == 2) begin
        rx_hold_len = 300;
      end
      phase_end = bytes_sent + 200;
      while (bytes_sent < phase_end) begin
        kind = $urandom_range(99, 0);
        n    = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 1) : $urandom_range(12, 1);
        if (kind < 70) begin
          send_message(n, n, 1'b1);
        end else if (kind < 80) begin
          len = $urandom_range(1, 0) ? 32'd0 : 32'($urandom);
          send_message(n, len, 1'b1);
        end else if (kind < 88) begin
          send_message(1, 32'd0, 1'b1);
        end else if (kind < 94) begin
          send_message(n, n, 1'b0);
        end else begin
          len = $urandom_range(1, 0) ? 32'd0 : 32'($urandom);
          push_byte(8'($urandom), $urandom_range(3, 0) == 0, len, $urandom_range(3, 0) == 0);
        end
      end
      phase++;
    end

    drain_stream();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
